>>> rtl/luma_edge_deblock_filter_defines.svh
// Assertion macros for the luma edge deblocking filter.
// Included by the top level; depends on nothing else.
`ifndef LUMA_EDGE_DEBLOCK_FILTER_DEFINES_SVH
`define LUMA_EDGE_DEBLOCK_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LEDF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LEDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ledf_pkg.sv
// Types and the single-line filter function of the luma edge deblocking filter.
// Used by luma_edge_deblock_filter; depends on nothing else.
package ledf_pkg;

  typedef logic [7:0] pixel_t;

  typedef struct packed {
    logic              func;
    logic [7:0]        edge_alpha;
    logic [4:0]        edge_beta;
    logic signed [5:0] clip_limit;
    pixel_t            left_px0;
    pixel_t            left_px1;
    pixel_t            left_px2;
    pixel_t            left_px3;
    pixel_t            right_px0;
    pixel_t            right_px1;
    pixel_t            right_px2;
    pixel_t            right_px3;
  } line_t;

  typedef struct packed {
    pixel_t left_out0;
    pixel_t left_out1;
    pixel_t left_out2;
    pixel_t right_out0;
    pixel_t right_out1;
    pixel_t right_out2;
  } result_t;

  typedef logic signed [11:0] sval_t;

  localparam sval_t PixMin = 12'sd0;
  localparam sval_t PixMax = 12'sd255;

  function automatic sval_t clip3(input sval_t v, input sval_t lo, input sval_t hi);
    sval_t r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [7:0] abs_diff(input pixel_t a, input pixel_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic sval_t sext(input pixel_t p);
    return $signed({4'b0000, p});
  endfunction

  function automatic result_t filter_line(input line_t ln);
    result_t     res;
    logic [7:0]  dpq;
    logic        edge_ok;
    logic        ap;
    logic        aq;
    logic        near;
    logic [6:0]  near_lim;
    sval_t       p0;
    sval_t       p1;
    sval_t       p2;
    sval_t       q0;
    sval_t       q1;
    sval_t       q2;
    sval_t       tc0;
    sval_t       tc;
    sval_t       avg;
    sval_t       dp1;
    sval_t       dq1;
    sval_t       dlt;
    sval_t       np0;
    sval_t       np1;
    sval_t       nq0;
    sval_t       nq1;
    logic [10:0] up0;
    logic [10:0] up1;
    logic [10:0] up2;
    logic [10:0] up3;
    logic [10:0] uq0;
    logic [10:0] uq1;
    logic [10:0] uq2;
    logic [10:0] uq3;
    logic [10:0] s_p0;
    logic [10:0] s_p1;
    logic [10:0] s_p2;
    logic [10:0] s_q0;
    logic [10:0] s_q1;
    logic [10:0] s_q2;
    logic [10:0] w_p0;
    logic [10:0] w_q0;

    dpq     = abs_diff(ln.left_px0, ln.right_px0);
    edge_ok = (dpq < ln.edge_alpha)
              && (abs_diff(ln.left_px1, ln.left_px0) < {3'b000, ln.edge_beta})
              && (abs_diff(ln.right_px1, ln.right_px0) < {3'b000, ln.edge_beta});
    ap      = abs_diff(ln.left_px2, ln.left_px0) < {3'b000, ln.edge_beta};
    aq      = abs_diff(ln.right_px2, ln.right_px0) < {3'b000, ln.edge_beta};
    near_lim = {1'b0, ln.edge_alpha[7:2]} + 7'd2;
    near    = {1'b0, dpq} < {2'b00, near_lim};

    res.left_out0  = ln.left_px0;
    res.left_out1  = ln.left_px1;
    res.left_out2  = ln.left_px2;
    res.right_out0 = ln.right_px0;
    res.right_out1 = ln.right_px1;
    res.right_out2 = ln.right_px2;

    // Normal mode.
    p0  = sext(ln.left_px0);
    p1  = sext(ln.left_px1);
    p2  = sext(ln.left_px2);
    q0  = sext(ln.right_px0);
    q1  = sext(ln.right_px1);
    q2  = sext(ln.right_px2);
    tc0 = {{6{ln.clip_limit[5]}}, ln.clip_limit};
    tc  = tc0 + sval_t'(ap) + sval_t'(aq);
    avg = (p0 + q0 + 12'sd1) >>> 1;
    dp1 = (p2 + avg - (p1 <<< 1)) >>> 1;
    dq1 = (q2 + avg - (q1 <<< 1)) >>> 1;
    np1 = p1 + clip3(dp1, -tc0, tc0);
    nq1 = q1 + clip3(dq1, -tc0, tc0);
    dlt = (((q0 - p0) <<< 2) + (p1 - q1) + 12'sd4) >>> 3;
    dlt = clip3(dlt, -tc, tc);
    np0 = clip3(p0 + dlt, PixMin, PixMax);
    nq0 = clip3(q0 - dlt, PixMin, PixMax);

    // Strong mode.
    up0  = {3'b000, ln.left_px0};
    up1  = {3'b000, ln.left_px1};
    up2  = {3'b000, ln.left_px2};
    up3  = {3'b000, ln.left_px3};
    uq0  = {3'b000, ln.right_px0};
    uq1  = {3'b000, ln.right_px1};
    uq2  = {3'b000, ln.right_px2};
    uq3  = {3'b000, ln.right_px3};
    s_p0 = (up2 + (up1 << 1) + (up0 << 1) + (uq0 << 1) + uq1 + 11'd4) >> 3;
    s_p1 = (up2 + up1 + up0 + uq0 + 11'd2) >> 2;
    s_p2 = ((up3 << 1) + (up2 << 1) + up2 + up1 + up0 + uq0 + 11'd4) >> 3;
    s_q0 = (up1 + (up0 << 1) + (uq0 << 1) + (uq1 << 1) + uq2 + 11'd4) >> 3;
    s_q1 = (up0 + uq0 + uq1 + uq2 + 11'd2) >> 2;
    s_q2 = ((uq3 << 1) + (uq2 << 1) + uq2 + uq1 + uq0 + up0 + 11'd4) >> 3;
    w_p0 = ((up1 << 1) + up0 + uq1 + 11'd2) >> 2;
    w_q0 = ((uq1 << 1) + uq0 + up1 + 11'd2) >> 2;

    if (edge_ok) begin
      if (!ln.func) begin
        if (!ln.clip_limit[5]) begin
          if (ap) begin
            res.left_out1 = np1[7:0];
          end
          if (aq) begin
            res.right_out1 = nq1[7:0];
          end
          res.left_out0  = np0[7:0];
          res.right_out0 = nq0[7:0];
        end
      end else if (near && ap) begin
        res.left_out0 = s_p0[7:0];
        res.left_out1 = s_p1[7:0];
        res.left_out2 = s_p2[7:0];
      end else begin
        res.left_out0 = w_p0[7:0];
      end
      if (ln.func) begin
        if (near && aq) begin
          res.right_out0 = s_q0[7:0];
          res.right_out1 = s_q1[7:0];
          res.right_out2 = s_q2[7:0];
        end else begin
          res.right_out0 = w_q0[7:0];
        end
      end
    end
    return res;
  endfunction

endpackage

>>> rtl/luma_edge_deblock_filter.sv
// Top level of the luma edge deblocking filter: input register, filter logic, result register.
// Depends on ledf_pkg and luma_edge_deblock_filter_defines.svh.
//
// Filters one line of eight luma pixels across a block edge per word, in normal or strong
// mode, and returns the six inner pixels. A word is accepted every cycle while the output
// side keeps taking results; the word is held in the input register, and the filter logic
// behind it loads the result register when that register is empty or its result is taken.
// in_stall_o rises only when both registers hold words and out_stall_i is high. No state
// is kept between words.
`include "luma_edge_deblock_filter_defines.svh"

module luma_edge_deblock_filter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  logic [7:0]           edge_alpha_i,
  input  logic [4:0]           edge_beta_i,
  input  logic signed [5:0]    clip_limit_i,
  input  ledf_pkg::pixel_t     left_px0_i,
  input  ledf_pkg::pixel_t     left_px1_i,
  input  ledf_pkg::pixel_t     left_px2_i,
  input  ledf_pkg::pixel_t     left_px3_i,
  input  ledf_pkg::pixel_t     right_px0_i,
  input  ledf_pkg::pixel_t     right_px1_i,
  input  ledf_pkg::pixel_t     right_px2_i,
  input  ledf_pkg::pixel_t     right_px3_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ledf_pkg::pixel_t     left_out0_o,
  output ledf_pkg::pixel_t     left_out1_o,
  output ledf_pkg::pixel_t     left_out2_o,
  output ledf_pkg::pixel_t     right_out0_o,
  output ledf_pkg::pixel_t     right_out1_o,
  output ledf_pkg::pixel_t     right_out2_o
);
  import ledf_pkg::*;

  line_t   line_q;
  line_t   line_d;
  logic    line_vld_q;
  result_t res_q;
  result_t res_d;
  logic    res_vld_q;
  logic    res_adv;
  logic    line_adv;

  assign res_adv    = !res_vld_q || !out_stall_i;
  assign line_adv   = !line_vld_q || res_adv;
  assign in_stall_o = !line_adv;

  assign line_d = '{
    func:       func_i,
    edge_alpha: edge_alpha_i,
    edge_beta:  edge_beta_i,
    clip_limit: clip_limit_i,
    left_px0:   left_px0_i,
    left_px1:   left_px1_i,
    left_px2:   left_px2_i,
    left_px3:   left_px3_i,
    right_px0:  right_px0_i,
    right_px1:  right_px1_i,
    right_px2:  right_px2_i,
    right_px3:  right_px3_i
  };

  assign res_d = filter_line(line_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (line_adv) begin
        line_vld_q <= in_valid_i;
      end
      if (res_adv) begin
        res_vld_q <= line_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_adv && in_valid_i) begin
      line_q <= line_d;
    end
    if (res_adv && line_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = res_vld_q;
  assign left_out0_o  = res_q.left_out0;
  assign left_out1_o  = res_q.left_out1;
  assign left_out2_o  = res_q.left_out2;
  assign right_out0_o = res_q.right_out0;
  assign right_out1_o = res_q.right_out1;
  assign right_out2_o = res_q.right_out2;

  `LEDF_ASSERT_SAME(a_stall_only_when_full, clk_i, rst_ni, in_stall_o,
                    line_vld_q && res_vld_q && out_stall_i, "input stalled without a full pipe")
  `LEDF_ASSERT_NEXT(a_line_reaches_output, clk_i, rst_ni, line_vld_q && !out_stall_i,
                    out_valid_o, "registered word did not reach the result register")
  `LEDF_ASSERT_NEXT(a_drain, clk_i, rst_ni, !line_vld_q && out_valid_o && !out_stall_i,
                    !out_valid_o, "result repeated after it was taken")

endmodule
